// ----- rtl/llh_pkg.sv -----
// shared widths and request codes for the log-linear latency histogram
package llh_pkg;

    localparam int LAT_W     = 48;   // signed latency field
    localparam int MAX_W     = 47;   // largest recorded latency
    localparam int CNT_W     = 48;   // total sample count
    localparam int QF_W      = 17;   // q16 quantile fraction
    localparam int QH_W      = 48;   // quantile in half microseconds
    localparam int CUM_W     = 49;   // running sum during a scan
    localparam int PLO_W     = 40;   // 16 x 24 partial product
    localparam int SUB_LOG   = 3;    // eight sub-buckets per octave
    localparam int S_DATA_W  = 72;   // 65 payload bits padded to bytes
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 144;  // 143 payload bits padded to bytes

    localparam logic [QF_W-1:0] Q_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

endpackage

// ----- rtl/log_linear_latency_histogram.sv -----
// log-linear latency histogram with bucket store and quantile scan
//
// usage
//   s_ channel: one beat per request, s_tuser selects the kind (record,
//   quantile query, clear, none). s_tdata carries the latency in microseconds
//   and the q16 quantile fraction. m_ channel: exactly one beat per
//   request with the quantile estimate in half microseconds (zero unless
//   a query), the sample count and the largest latency after the request.
//   bucket counts live in one ram of OCTAVES*8+1 entries, one port.
//   record: bin and read, then increment and write back; the result is
//   registered in the write-back step.
//   query: ST_MUL and ST_TGT form the target rank (two 16x24 multiplies),
//   then one bucket per cycle through the ram port until the rank is reached
//   or the store ends, then ST_MID forms the bucket midpoint. an empty store
//   answers straight from idle.
//   clear: a pass over the ram, then the result.
//   reset: the same clearing pass runs with s_tready low, and no result is
//   produced for it.
//   stall: the result waits in the output register; a new beat is taken
//   in the same cycle the old result is taken, never earlier.
module log_linear_latency_histogram #(
    parameter int OCTAVES      = 24,
    parameter int BUCKET_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [47:0] latency_us (signed), [64:48] quantile_q16, [71:65] zero
    input  logic [llh_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [llh_pkg::S_USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [47:0] quantile_half_us, [95:48] sample_count,
    // [142:96] max_latency_us, [143] zero
    output logic [llh_pkg::M_DATA_W-1:0] m_tdata
);

    import llh_pkg::*;

    localparam int NB       = OCTAVES * 8 + 1;
    localparam int AW       = $clog2(NB);
    localparam logic [AW-1:0] OVF_IDX  = AW'(OCTAVES * 8);
    localparam logic [AW-1:0] LAST_IDX = AW'(NB - 1);
    localparam logic [QH_W-1:0] OVF_MID2 = QH_W'(8) << OCTAVES;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC,
        ST_MUL,
        ST_TGT,
        ST_SCAN,
        ST_MID
    } state_t;

    // bucket index of a non-negative latency
    function automatic logic [AW-1:0] bin_of(input logic [MAX_W-1:0] v);
        logic [5:0]       t;
        logic [5:0]       oct;
        logic [MAX_W-1:0] sh;
        logic [2:0]       sub;
        t = '0;
        for (int i = 3; i < MAX_W; i++) begin
            if (v[i]) begin
                t = 6'(i);
            end
        end
        oct = t - 6'd2;
        sh  = v >> (t - 6'd3);
        sub = sh[2:0];
        if (v < MAX_W'(8)) begin
            return AW'(v[2:0]);
        end else if (int'(oct) >= OCTAVES) begin
            return OVF_IDX;
        end else begin
            return AW'({oct, sub});
        end
    endfunction

    // twice the bucket midpoint, twice the lower bound for overflow
    function automatic logic [QH_W-1:0] mid2_of(input logic [AW-1:0] idx);
        logic [AW-SUB_LOG-1:0] oct;
        logic [2:0]            sub;
        oct = idx[AW-1:SUB_LOG];
        sub = idx[2:0];
        if (idx == OVF_IDX) begin
            return OVF_MID2;
        end else if (oct == '0) begin
            return QH_W'({sub, 1'b1});
        end else begin
            return (QH_W'({1'b1, sub}) << oct) + (QH_W'(1) << (oct - 1'b1));
        end
    endfunction

    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               clr_pend_reg, clr_pend_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [MAX_W-1:0]   max_reg, max_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               issue_done_reg, issue_done_next;
    logic [QF_W-1:0]    q_reg, q_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [PLO_W-1:0]   plo_reg, plo_next;
    logic [CNT_W-1:0]   target_reg, target_next;
    logic [CUM_W-1:0]   cum_reg, cum_next;
    logic [QH_W-1:0]    res_q_reg, res_q_next;

    // ram port
    logic [AW-1:0]           mem_addr;
    logic                    mem_we;
    logic [BUCKET_WIDTH-1:0] mem_wdata;
    logic [BUCKET_WIDTH-1:0] mem_rdata;

    llh_ram #(
        .WIDTH (BUCKET_WIDTH),
        .DEPTH (NB)
    ) u_bucket_ram (
        .aclk  (aclk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // input fields
    req_t             in_req;
    logic [LAT_W-1:0] in_lat;
    logic [QF_W-1:0]  in_q;
    logic [MAX_W-1:0] lat_clamped;
    logic             s_accept;
    logic             out_free;

    assign in_req      = req_t'(s_tuser[1:0]);
    assign in_lat      = s_tdata[LAT_W-1:0];
    assign in_q        = s_tdata[LAT_W+QF_W-1:LAT_W];
    assign lat_clamped = in_lat[LAT_W-1] ? '0 : in_lat[MAX_W-1:0];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // target rank arithmetic
    logic [PLO_W-1:0]  phi;
    logic [63:0]       prod;
    logic [63:0]       prod_rnd;
    logic [CNT_W-1:0]  tgt_raw;
    logic [CUM_W-1:0]  cum_sum;
    logic [QH_W-1:0]   cap;
    logic [QH_W-1:0]   mid2;

    assign phi      = PLO_W'(q_reg[15:0] * count_reg[47:24]);
    assign prod     = {phi, 24'b0} + 64'(plo_reg);
    assign prod_rnd = prod + 64'hFFFF;
    assign tgt_raw  = prod_rnd[63:16];
    assign cum_sum  = cum_reg + CUM_W'(mem_rdata);
    assign cap      = {max_reg, 1'b0};
    assign mid2     = mid2_of(idx_reg);

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        clr_pend_next   = clr_pend_reg;
        count_next      = count_reg;
        max_next        = max_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        rd_vld_next     = 1'b0;
        issue_done_next = issue_done_reg;
        q_next          = q_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        plo_next        = plo_reg;
        target_next     = target_reg;
        cum_next        = cum_reg;
        res_q_next      = res_q_reg;
        mem_addr        = addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                    if (clr_pend_reg) begin
                        m_tvalid_next = 1'b1;
                        res_q_next    = '0;
                    end
                    clr_pend_next = 1'b0;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                mem_addr = bin_of(lat_clamped);
                if (s_accept) begin
                    case (in_req)
                        REQ_RECORD: begin
                            idx_next = bin_of(lat_clamped);
                            if (count_reg != '1) begin
                                count_next = count_reg + 1'b1;
                            end
                            if (lat_clamped > max_reg) begin
                                max_next = lat_clamped;
                            end
                            state_next = ST_REC;
                        end
                        REQ_QUERY: begin
                            if (count_reg == '0) begin
                                m_tvalid_next = 1'b1;
                                res_q_next    = '0;
                            end else begin
                                q_next     = (in_q > Q_ONE) ? Q_ONE : in_q;
                                state_next = ST_MUL;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next    = '0;
                            max_next      = '0;
                            addr_next     = '0;
                            clr_pend_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            res_q_next    = '0;
                        end
                    endcase
                end
            end
            ST_REC: begin
                // increment the bucket read last cycle, saturating
                mem_addr  = idx_reg;
                mem_we    = 1'b1;
                mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
                m_tvalid_next = 1'b1;
                res_q_next    = '0;
                state_next    = ST_IDLE;
            end
            ST_MUL: begin
                plo_next   = PLO_W'(q_reg[15:0] * count_reg[23:0]);
                state_next = ST_TGT;
            end
            ST_TGT: begin
                if (q_reg[QF_W-1]) begin
                    target_next = count_reg;
                end else if (tgt_raw == '0) begin
                    target_next = CNT_W'(1);
                end else begin
                    target_next = tgt_raw;
                end
                addr_next       = '0;
                cum_next        = '0;
                issue_done_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                // one read issued per cycle, checked the cycle after
                if (!issue_done_reg) begin
                    rd_vld_next  = 1'b1;
                    chk_idx_next = addr_reg;
                    if (addr_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                if (rd_vld_reg) begin
                    cum_next = cum_sum;
                    if (cum_sum >= CUM_W'(target_reg)) begin
                        idx_next    = chk_idx_reg;
                        rd_vld_next = 1'b0;
                        state_next  = ST_MID;
                    end else if (chk_idx_reg == LAST_IDX) begin
                        // saturated counts never reach the rank
                        m_tvalid_next = 1'b1;
                        res_q_next    = cap;
                        rd_vld_next   = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_MID: begin
                m_tvalid_next = 1'b1;
                res_q_next    = (mid2 < cap) ? mid2 : cap;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            clr_pend_reg   <= 1'b0;
            count_reg      <= '0;
            max_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            issue_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            clr_pend_reg   <= clr_pend_next;
            count_reg      <= count_next;
            max_reg        <= max_next;
            m_tvalid_reg   <= m_tvalid_next;
            rd_vld_reg     <= rd_vld_next;
            issue_done_reg <= issue_done_next;
        end
        q_reg       <= q_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        plo_reg     <= plo_next;
        target_reg  <= target_next;
        cum_reg     <= cum_next;
        res_q_reg   <= res_q_next;
    end

    // count and max only change after the held beat is taken
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, max_reg, count_reg, res_q_reg};

endmodule

// ----- rtl/llh_ram.sv -----
// generic single-port ram with registered read, read-before-write
module llh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 193
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- verif/tb_log_linear_latency_histogram.sv -----
// self-checking stream testbench for the log-linear latency histogram
module tb_log_linear_latency_histogram;
    import llh_pkg::*;

    localparam int OCTAVES      = 24;
    localparam int BUCKET_WIDTH = 32;
    localparam int NBUCKETS     = OCTAVES * 8 + 1;
    localparam int OVF_BUCKET   = OCTAVES * 8;
    localparam int RANDOM_REQS  = 850;
    // worst beat: a full query scan plus a long send gap and a long stall,
    // summed over ~900 beats, then taken a few times over
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = OCTAVES * 8 + 16;

    typedef struct {
        req_t              kind;
        logic [LAT_W-1:0]  lat;
        logic [QF_W-1:0]   q;
        bit                wait_idle;
    } request_t;

    typedef struct packed {
        logic [MAX_W-1:0] max_lat;
        logic [CNT_W-1:0] count;
        logic [QH_W-1:0]  q_half;
    } answer_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [S_USER_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // predictor state
    logic [BUCKET_WIDTH-1:0] hist_bucket [NBUCKETS];
    logic [CNT_W-1:0]        hist_total;
    logic [MAX_W-1:0]        hist_max;

    request_t    request_q[$];
    answer_t     answer_q[$];
    logic        s_beat_done = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    bit          calm_send   = 1'b0;
    bit          calm_recv   = 1'b0;

    log_linear_latency_histogram #(
        .OCTAVES     (OCTAVES),
        .BUCKET_WIDTH(BUCKET_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_histogram();
        int i;
        for (i = 0; i < NBUCKETS; i++) begin
            hist_bucket[i] = '0;
        end
        hist_total = '0;
        hist_max   = '0;
    endfunction

    function automatic int unsigned bucket_index(logic [LAT_W-1:0] v);
        int unsigned msb, oct, sub;
        logic [LAT_W-1:0] base;
        int i;
        if (v < 8) begin
            return 32'(v[2:0]);
        end
        msb = 0;
        for (i = 0; i < LAT_W; i++) begin
            if (v[i]) begin
                msb = i;
            end
        end
        oct = msb - 2;
        if (oct >= OCTAVES) begin
            return OVF_BUCKET;
        end
        base = 48'd8 << (oct - 1);
        sub  = 32'((v - base) >> (oct - 1));
        if (sub > 7) begin
            sub = 7;
        end
        return oct * 8 + sub;
    endfunction

    // bucket midpoint doubled, lower bound doubled for the overflow bucket
    function automatic logic [63:0] bucket_mid2(int unsigned idx);
        int unsigned oct, sub;
        logic [63:0] base, step;
        if (idx >= OVF_BUCKET) begin
            return (64'd8 << (OCTAVES - 1)) * 2;
        end
        oct  = idx / 8;
        sub  = idx % 8;
        base = (oct == 0) ? 64'd0 : (64'd8 << (oct - 1));
        step = (oct <= 1) ? 64'd1 : (64'd1 << (oct - 1));
        return 2 * (base + sub * step) + step;
    endfunction

    function automatic logic [QH_W-1:0] quantile_estimate(logic [QF_W-1:0] q_in);
        logic [65:0] target;
        logic [63:0] cum, mid2, cap;
        logic [QF_W-1:0] q;
        int i;
        if (hist_total == 0) begin
            return '0;
        end
        q      = (q_in > Q_ONE) ? Q_ONE : q_in;
        target = (66'(q) * 66'(hist_total) + 66'd65535) >> 16;
        if (target == 0) begin
            target = 1;
        end
        if (target > hist_total) begin
            target = hist_total;
        end
        cap = 64'(hist_max) * 2;
        cum = '0;
        for (i = 0; i < NBUCKETS; i++) begin
            cum += hist_bucket[i];
            if (cum >= target) begin
                mid2 = bucket_mid2(i);
                return QH_W'((mid2 < cap) ? mid2 : cap);
            end
        end
        return QH_W'(cap);
    endfunction

    function automatic answer_t histogram_step(logic [1:0] kind, logic [LAT_W-1:0] lat,
                                               logic [QF_W-1:0] q);
        answer_t ans;
        int unsigned idx;
        ans.q_half = '0;
        case (req_t'(kind))
            REQ_RECORD: begin
                if (lat[LAT_W-1]) begin
                    lat = '0;
                end
                idx = bucket_index(lat);
                if (hist_bucket[idx] != '1) begin
                    hist_bucket[idx] = hist_bucket[idx] + 1'b1;
                end
                if (hist_total != '1) begin
                    hist_total = hist_total + 1'b1;
                end
                if (lat[MAX_W-1:0] > hist_max) begin
                    hist_max = lat[MAX_W-1:0];
                end
            end
            REQ_QUERY: begin
                ans.q_half = quantile_estimate(q);
            end
            REQ_CLEAR: begin
                clear_histogram();
            end
            default: begin
            end
        endcase
        ans.count   = hist_total;
        ans.max_lat = hist_max;
        return ans;
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [LAT_W-1:0] rand_latency();
        logic [63:0] r;
        logic [LAT_W-1:0] mask;
        int unsigned pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            return LAT_W'($urandom_range(0, 20));
        end
        if (pick < 70) begin
            mask = (48'd1 << $urandom_range(1, 32)) - 48'd1;
            return {1'b0, r[46:0]} & mask;
        end
        if (pick < 80) begin
            return {1'b1, r[46:0]};
        end
        if (pick < 90) begin
            return r[47:0];
        end
        // around the overflow boundary
        return (48'd8 << (OCTAVES - 1)) - 48'd4 + LAT_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [QF_W-1:0] rand_fraction();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            return QF_W'($urandom_range(0, 17'h1FFFF));
        end
        if (pick < 80) begin
            return QF_W'($urandom_range(0, 65536));
        end
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'd65535;
            3:       return Q_ONE;
            4:       return 17'd65537;
            default: return 17'h1FFFF;
        endcase
    endfunction

    task automatic add_request(req_t kind, logic [LAT_W-1:0] lat, logic [QF_W-1:0] q,
                               bit wait_idle);
        request_t r;
        r.kind      = kind;
        r.lat       = lat;
        r.q         = q;
        r.wait_idle = wait_idle;
        request_q.push_back(r);
    endtask

    // driver: beats change on the falling edge
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_done) begin
            if (s_beat_done) begin
                if ($urandom_range(0, 59) == 0) begin
                    calm_send = ~calm_send;
                end
                send_gap = pick_gap(calm_send);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0 &&
                         !(request_q[0].wait_idle && answer_q.size() != 0)) begin
                r = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.kind;
                s_tdata  <= {7'd0, r.q, r.lat};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 79) == 0) begin
                    calm_recv = ~calm_recv;
                end
                stall_left = pick_gap(calm_recv);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: check the result beat first, then predict the accepted request
    always @(posedge aclk) begin
        answer_t got, want;
        if (!aresetn) begin
            s_beat_done <= 1'b0;
        end else begin
            s_beat_done <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got = m_tdata[QH_W+CNT_W+MAX_W-1:0];
                if (answer_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: quantile %0d count %0d max %0d",
                                 got.q_half, got.count, got.max_lat);
                    end
                end else begin
                    want = answer_q.pop_front();
                    if (got.q_half !== want.q_half || got.count !== want.count ||
                        got.max_lat !== want.max_lat) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: quantile exp %0d got %0d, count exp %0d got %0d, max exp %0d got %0d",
                                     want.q_half, got.q_half, want.count, got.count,
                                     want.max_lat, got.max_lat);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                answer_q.push_back(histogram_step(s_tuser, s_tdata[LAT_W-1:0],
                                                  s_tdata[LAT_W+QF_W-1:LAT_W]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned n, pick;
        req_t kind;
        clear_histogram();

        // directed part
        add_request(REQ_QUERY,  48'd0, 17'd32768, 1'b0);      // empty store
        add_request(REQ_RECORD, 48'd0, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd7, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd8, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd15, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd16, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'hFFFF_FFFF_FFFF, 17'h1FFFF, 1'b0);   // negative
        add_request(REQ_RECORD, 48'h8000_0000_0000, 17'd0, 1'b0);       // most negative
        add_request(REQ_RECORD, (48'd8 << (OCTAVES - 1)) - 48'd1, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd8 << (OCTAVES - 1), 17'd0, 1'b0);   // overflow bucket
        add_request(REQ_RECORD, 48'h7FFF_FFFF_FFFF, 17'd0, 1'b0);
        add_request(REQ_QUERY,  48'd0, 17'd0, 1'b0);
        add_request(REQ_QUERY,  48'd0, 17'd1, 1'b0);
        add_request(REQ_QUERY,  48'h7FFF_FFFF_FFFF, 17'd32768, 1'b0);
        add_request(REQ_QUERY,  48'd0, Q_ONE, 1'b0);
        add_request(REQ_QUERY,  48'd0, 17'd65537, 1'b0);        // above one
        add_request(REQ_QUERY,  48'hFFFF_FFFF_FFFF, 17'h1FFFF, 1'b0);
        add_request(REQ_NONE,   48'h1234_5678_9ABC, 17'd40000, 1'b0);
        add_request(REQ_CLEAR,  48'd0, 17'd0, 1'b0);
        add_request(REQ_QUERY,  48'd0, Q_ONE, 1'b0);            // empty after clear
        add_request(REQ_RECORD, 48'd3, 17'd0, 1'b0);
        add_request(REQ_RECORD, 48'd99, 17'd0, 1'b0);
        add_request(REQ_QUERY,  48'd0, Q_ONE, 1'b1);            // midpoint capped at max

        // random part
        for (n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 999);
            if (pick < 15) begin
                kind = REQ_CLEAR;
            end else if (pick < 35) begin
                kind = REQ_NONE;
            end else if (pick < 150) begin
                kind = REQ_QUERY;
            end else begin
                kind = REQ_RECORD;
            end
            add_request(kind, rand_latency(), rand_fraction(), $urandom_range(0, 39) == 0);
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (answer_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        fail_count += answer_q.size();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
